[rtl/core/bmc_pkg.sv]
`default_nettype none

package bmc_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned N_WORDS  = 4;
  localparam int unsigned BLK_BYTES = 16;
  localparam int unsigned N_ROUNDS = 8;

  typedef logic [WORD_W-1:0] word_t;

  // mixing network multipliers and addends
  localparam word_t MIX_K0 = 32'd32633;
  localparam word_t MIX_K1 = 32'd65419;
  localparam word_t MIX_K2 = 32'd65469;
  localparam word_t MIX_K3 = 32'd32717;
  localparam word_t MIX_K4 = 32'd65497;
  localparam word_t MIX_K5 = 32'd131009;

endpackage

`default_nettype wire

[rtl/core/bmc_if.sv]
`default_nettype none

interface bmc_in_if
  import bmc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               mode;
  word_t              word0;
  word_t              word1;
  word_t              word2;
  word_t              word3;
  logic [COUNT_W-1:0] valid_bytes;

  modport source (output valid, mode, word0, word1, word2, word3, valid_bytes,
                  input ready);
  modport sink   (input valid, mode, word0, word1, word2, word3, valid_bytes,
                  output ready);
endinterface

interface bmc_out_if
  import bmc_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t sum0;
  word_t sum1;
  word_t sum2;
  word_t sum3;

  modport source (output valid, sum0, sum1, sum2, sum3, input ready);
  modport sink   (input valid, sum0, sum1, sum2, sum3, output ready);
endinterface

`default_nettype wire

[rtl/core/block_mix_checksum_128.sv]
`default_nettype none
// 128-bit running checksum over 16-byte blocks.
// in_ch carries one item: mode 0 clears the four running sums, mode 1 brings
// a block as four little-endian words plus a count of valid bytes (bytes past
// the count are zeroed, a count above 16 counts as 16, a count of 0 leaves the
// sums alone). out_ch returns the four sums after every item, one result per
// item, both channels valid/ready.
// A hashed block runs eight mixing rounds on one shared 32x32 multiplier; each
// round needs three dependent products, so a round runs as three phases (P0,
// M, F). After the mix the item passes through the final state and its sums
// go to the output register (a clear or empty item goes there straight from
// idle), and a new item is taken only once the block is back in idle, the
// multiplier chain being the limit.
// The result sits in an output register; the next item is accepted while it
// waits, and a finished item holds in the final state until the receiver has
// taken the previous result.
// Reset (rst_n low, synchronous) clears the sums and drops any item in flight.
module block_mix_checksum_128
  import bmc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bmc_in_if.sink     in_ch,
  bmc_out_if.source  out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_KEEP  = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;

  localparam logic [1:0] PH_P0 = 2'd0;
  localparam logic [1:0] PH_M  = 2'd1;
  localparam logic [1:0] PH_F  = 2'd2;

  localparam int unsigned RND_W = $clog2(N_ROUNDS);

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       op_r;
  logic [1:0]       phase_r, phase_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             out_valid_r, out_valid_nxt;

  word_t s_r  [N_WORDS];
  word_t sum_r[N_WORDS];
  word_t p0_r, p1_r, p2_r, p3_r, m_r;

  logic  in_fire, fin_go, last_round;
  word_t blk    [N_WORDS];
  word_t mul_k, mul_x, prod, f_val, g_val;
  logic [COUNT_W-1:0] cnt_sat;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign fin_go      = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign last_round  = (rnd_r == RND_W'(N_ROUNDS - 1));

  // byte masking of the incoming block
  always_comb begin
    logic [BLK_BYTES*8-1:0] raw, kept;
    raw = {in_ch.word3, in_ch.word2, in_ch.word1, in_ch.word0};
    cnt_sat = (in_ch.valid_bytes > COUNT_W'(BLK_BYTES)) ? COUNT_W'(BLK_BYTES)
                                                        : in_ch.valid_bytes;
    for (int b = 0; b < BLK_BYTES; b++) begin
      kept[b*8 +: 8] = (COUNT_W'(b) < cnt_sat) ? raw[b*8 +: 8] : 8'd0;
    end
    for (int w = 0; w < N_WORDS; w++) begin
      blk[w] = kept[w*WORD_W +: WORD_W];
    end
  end

  // shared multiplier, operands picked by phase
  always_comb begin
    unique case (phase_r)
      PH_P0:   begin mul_k = MIX_K0; mul_x = s_r[0]; end
      PH_M:    begin mul_k = MIX_K4; mul_x = p0_r ^ p2_r; end
      PH_F:    begin mul_k = MIX_K5; mul_x = (p1_r ^ p3_r) + m_r; end
      default: begin mul_k = MIX_K0; mul_x = s_r[0]; end
    endcase
    prod  = WORD_W'(mul_k * mul_x);
    f_val = prod;
    g_val = m_r + prod;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.mode && in_ch.valid_bytes != '0) ? ST_MIX : ST_FIN;
          phase_nxt = PH_P0;
          rnd_nxt   = '0;
        end
      end
      ST_MIX: begin
        if (phase_r == PH_F) begin
          phase_nxt = PH_P0;
          rnd_nxt   = rnd_r + 1'b1;
          if (last_round) begin
            state_nxt = ST_FIN;
            rnd_nxt   = '0;
          end
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_P0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
      op_r        <= OP_CLEAR;
      for (int i = 0; i < N_WORDS; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        if (!in_ch.mode) begin
          op_r <= OP_CLEAR;
        end else if (in_ch.valid_bytes == '0) begin
          op_r <= OP_KEEP;
        end else begin
          op_r <= OP_ADD;
        end
      end
      if (fin_go) begin
        for (int i = 0; i < N_WORDS; i++) begin
          case (op_r)
            OP_CLEAR: sum_r[i] <= '0;
            OP_ADD:   sum_r[i] <= sum_r[i] + s_r[(i + 1) % N_WORDS];
            default:  sum_r[i] <= sum_r[i];
          endcase
        end
      end
    end
  end

  // working registers of the mix, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < N_WORDS; i++) begin
        s_r[i] <= blk[i];
      end
    end else if (state_r == ST_MIX) begin
      unique case (phase_r)
        PH_P0: begin
          p0_r <= prod;
          p1_r <= MIX_K1 + s_r[1];
          p2_r <= MIX_K2 + s_r[2];
          p3_r <= MIX_K3 + s_r[3];
        end
        PH_M: m_r <= prod;
        PH_F: begin
          s_r[0] <= p0_r ^ f_val;
          s_r[1] <= p1_r ^ g_val;
          s_r[2] <= p2_r ^ f_val;
          s_r[3] <= p3_r ^ g_val;
        end
        default: m_r <= m_r;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.sum0  = sum_r[0];
  assign out_ch.sum1  = sum_r[1];
  assign out_ch.sum2  = sum_r[2];
  assign out_ch.sum3  = sum_r[3];

`ifndef ASSERT_OFF
  // sequencer counters rest outside the mix
  a_counters_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_MIX) |-> (phase_r == PH_P0 && rnd_r == '0))
    else $error("round counters not at rest outside mix");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_P0 || phase_r == PH_M || phase_r == PH_F))
    else $error("illegal mix phase");

  // a clear item leaves all sums at zero
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && op_r == OP_CLEAR) |=>
      (sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0 && sum_r[3] == '0))
    else $error("sums not zero after clear item");

  // sums only move when an item finishes
  a_sums_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(fin_go)) |->
      ($stable(sum_r[0]) && $stable(sum_r[1]) && $stable(sum_r[2]) &&
       $stable(sum_r[3])))
    else $error("running sums changed without a finished item");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bmc_pkg::*;

  localparam bit MODE_CLEAR = 1'b0;
  localparam bit MODE_HASH  = 1'b1;
  localparam int unsigned ITEMS_PER_PHASE = 400;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef word_t [N_WORDS-1:0] sums_t;

  typedef struct packed {
    logic               mode;
    word_t              w3;
    word_t              w2;
    word_t              w1;
    word_t              w0;
    logic [COUNT_W-1:0] nbytes;
  } blk_item_t;

  typedef struct {
    blk_item_t item;
    bit        typed;
    sums_t     want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  bmc_in_if  in_ch ();
  bmc_out_if out_ch ();

  block_mix_checksum_128 u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  sums_t       model_sums;
  sums_t       pending_sums[$];
  dir_row_t    dir_rows[$];
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned mismatch_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // eight rounds of the mixing network, all arithmetic wraps at 32 bits
  function automatic sums_t mix_block(sums_t s);
    word_t p0, p1, p2, p3, x02, x13, m, t, f, g;
    for (int r = 0; r < N_ROUNDS; r++) begin
      p0  = MIX_K0 * s[0];
      p1  = MIX_K1 + s[1];
      p2  = MIX_K2 + s[2];
      p3  = MIX_K3 + s[3];
      x02 = p0 ^ p2;
      x13 = p1 ^ p3;
      m   = MIX_K4 * x02;
      t   = x13 + m;
      f   = MIX_K5 * t;
      g   = m + f;
      s[0] = p0 ^ f;
      s[1] = p1 ^ g;
      s[2] = p2 ^ f;
      s[3] = p3 ^ g;
    end
    return s;
  endfunction

  // advances the running sums by one item and returns them
  function automatic sums_t step_checksum(blk_item_t it);
    sums_t       blk;
    int unsigned cnt;
    if (it.mode == MODE_CLEAR) begin
      model_sums = '0;
    end else if (it.nbytes != 0) begin
      cnt = (it.nbytes > BLK_BYTES) ? BLK_BYTES : it.nbytes;
      blk = {it.w3, it.w2, it.w1, it.w0};
      for (int b = 0; b < BLK_BYTES; b++) begin
        if (b >= cnt) blk[b / 4][8 * (b % 4) +: 8] = 8'h00;
      end
      blk = mix_block(blk);
      for (int i = 0; i < N_WORDS; i++) begin
        model_sums[i] = model_sums[i] + blk[(i + 1) % N_WORDS];
      end
    end
    return model_sums;
  endfunction

  task automatic add_row(input logic mode, input word_t w0, input word_t w1,
                         input word_t w2, input word_t w3,
                         input logic [COUNT_W-1:0] nbytes,
                         input bit typed, input sums_t want);
    dir_row_t row;
    row.item  = '{mode: mode, w3: w3, w2: w2, w1: w1, w0: w0, nbytes: nbytes};
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // holds the item on the channel until it is taken
  task automatic send_item(input blk_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= it.mode;
    in_ch.word0       <= it.w0;
    in_ch.word1       <= it.w1;
    in_ch.word2       <= it.w2;
    in_ch.word3       <= it.w3;
    in_ch.valid_bytes <= it.nbytes;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 10) return '1;
    return $urandom;
  endfunction

  function automatic blk_item_t rand_item();
    blk_item_t   it;
    int unsigned pick;
    it.mode = ($urandom_range(99) < 6) ? MODE_CLEAR : MODE_HASH;
    it.w0 = rand_word();
    it.w1 = rand_word();
    it.w2 = rand_word();
    it.w3 = rand_word();
    pick = $urandom_range(99);
    if (pick < 65)      it.nbytes = COUNT_W'($urandom_range(1, 15));
    else if (pick < 80) it.nbytes = COUNT_W'(BLK_BYTES);
    else if (pick < 90) it.nbytes = '0;
    else                it.nbytes = COUNT_W'($urandom_range(17, 31));
    return it;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    sums_t got;
    sums_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.sum3, out_ch.sum2, out_ch.sum1, out_ch.sum0};
      if (pending_sums.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: sums %h %h %h %h", got[0], got[1], got[2], got[3]);
      end else begin
        want = pending_sums.pop_front();
        for (int i = 0; i < N_WORDS; i++) begin
          if (got[i] !== want[i]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("sum%0d mismatch: expected %h, got %h", i, want[i], got[i]);
          end
        end
      end
    end
  end

  initial begin
    blk_item_t it;
    sums_t     pred;
    int        phase_idle[4];
    int        phase_stall[4];

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_CLEAR;
    in_ch.word0       <= '0;
    in_ch.word1       <= '0;
    in_ch.word2       <= '0;
    in_ch.word3       <= '0;
    in_ch.valid_bytes <= '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    mismatch_cnt  = 0;
    model_sums    = '0;
    phase_idle  = '{0, 45, 0, 14};
    phase_stall = '{0, 0, 45, 14};

    // empty block and clear right after reset read back as zeros
    add_row(MODE_HASH, '1, '1, '1, '1, 5'd0, 1'b1, '0);
    add_row(MODE_CLEAR, '1, '1, '1, '1, 5'd31, 1'b1, '0);
    add_row(MODE_HASH, '1, '1, '1, '1, 5'd16, 1'b0, '0);
    add_row(MODE_HASH, '1, '1, '1, '1, 5'd1, 1'b0, '0);
    add_row(MODE_HASH, 32'hA5A5_5A5A, 32'h0123_4567, 32'h89AB_CDEF, 32'hFFFF_0000,
            5'd2, 1'b0, '0);
    add_row(MODE_HASH, 32'hA5A5_5A5A, 32'h0123_4567, 32'h89AB_CDEF, 32'hFFFF_0000,
            5'd3, 1'b0, '0);
    add_row(MODE_HASH, '1, '1, '1, '1, 5'd4, 1'b0, '0);
    add_row(MODE_HASH, '1, '1, '1, '1, 5'd5, 1'b0, '0);
    add_row(MODE_HASH, '1, '1, '1, '1, 5'd8, 1'b0, '0);
    add_row(MODE_HASH, '1, '1, '1, '1, 5'd9, 1'b0, '0);
    add_row(MODE_HASH, '1, '1, '1, '1, 5'd12, 1'b0, '0);
    add_row(MODE_HASH, '1, '1, '1, '1, 5'd13, 1'b0, '0);
    add_row(MODE_HASH, '1, '1, '1, '1, 5'd15, 1'b0, '0);
    // oversized counts behave as a full block
    add_row(MODE_HASH, 32'hDEAD_BEEF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
            5'd17, 1'b0, '0);
    add_row(MODE_HASH, 32'hDEAD_BEEF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
            5'd31, 1'b0, '0);
    // empty block keeps nonzero sums
    add_row(MODE_HASH, 32'h1234_5678, '1, '1, '1, 5'd0, 1'b0, '0);
    add_row(MODE_HASH, '0, '0, '0, '0, 5'd16, 1'b0, '0);
    add_row(MODE_CLEAR, 32'h5555_5555, 32'hAAAA_AAAA, '0, '1, 5'd16, 1'b1, '0);
    add_row(MODE_HASH, '0, '0, '0, '0, 5'd16, 1'b0, '0);
    add_row(MODE_HASH, 32'h8000_0000, 32'h0000_0001, 32'h0000_8000, 32'h0001_0000,
            5'd16, 1'b0, '0);
    add_row(MODE_CLEAR, '0, '0, '0, '0, 5'd0, 1'b1, '0);
    add_row(MODE_HASH, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3C3C_3C3C, 32'hC3C3_C3C3,
            5'd7, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].item);
      pred = step_checksum(dir_rows[r].item);
      pending_sums.push_back(dir_rows[r].typed ? dir_rows[r].want : pred);
    end
    // sender holds off until every directed result is back
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      in_idle_pct   = phase_idle[p];
      out_stall_pct = phase_stall[p];
      repeat (ITEMS_PER_PHASE) begin
        it = rand_item();
        send_item(it);
        pending_sums.push_back(step_checksum(it));
      end
      wait_drained();
    end

    out_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_sums.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
